// ===== hw/rtl/tbs_pkg.sv =====
// shared types and constants for the triple buffer swap controller
package tbs_pkg;

    // largest lock count a consumer group may hold
    localparam int MAX_LOCKS = 255;

    localparam int LOCK_W = 8;

    // effective limit, clipped to what the 8-bit count can hold
    localparam int LOCK_LIMIT_I = (MAX_LOCKS < 255) ? MAX_LOCKS : 255;
    localparam logic [LOCK_W-1:0] LOCK_LIMIT = LOCK_LIMIT_I[LOCK_W-1:0];

    localparam int SLOT_W = 2;
    localparam int INDEX_W = 32;
    localparam int READY_INDEX_W = 31;

    // frame index that marks an empty slot
    localparam logic signed [INDEX_W-1:0] EMPTY_INDEX = -32'sd1;

    // reset roles of the three slots
    localparam logic [SLOT_W-1:0] FRONT_RESET = 2'd0;
    localparam logic [SLOT_W-1:0] MIDDLE_RESET = 2'd1;
    localparam logic [SLOT_W-1:0] BACK_RESET = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOCK    = 2'd0,
        CMD_UNLOCK  = 2'd1,
        CMD_PUBLISH = 2'd2,
        CMD_NONE    = 2'd3
    } command_t;

    // one input item
    typedef struct packed {
        logic [1:0]                command;
        logic signed [INDEX_W-1:0] frame_index;
    } cmd_item_t;

    // one result item
    typedef struct packed {
        logic [SLOT_W-1:0]        slot;
        logic                     ready_res;
        logic [READY_INDEX_W-1:0] ready_frame_index;
        logic                     error;
        logic [LOCK_W-1:0]        locks_held;
    } res_item_t;

endpackage

// ===== hw/rtl/tbs_cmd_if.sv =====
// command channel carrying lock, unlock and publish items
interface tbs_cmd_if;
    import tbs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic signed [INDEX_W-1:0] frame_index;

    modport source (output valid, output command, output frame_index, input ready);
    modport sink (input valid, input command, input frame_index, output ready);
endinterface

// ===== hw/rtl/tbs_res_if.sv =====
// result channel carrying one item per accepted command
interface tbs_res_if;
    import tbs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [SLOT_W-1:0]        slot;
    logic                     ready_res;
    logic [READY_INDEX_W-1:0] ready_frame_index;
    logic                     error;
    logic [LOCK_W-1:0]        locks_held;

    modport source (
        output valid, output slot, output ready_res, output ready_frame_index,
        output error, output locks_held, input ready
    );
    modport sink (
        input valid, input slot, input ready_res, input ready_frame_index,
        input error, input locks_held, output ready
    );
endinterface

// ===== hw/rtl/tbs_in_stage.sv =====
// input register holding the next command item
module tbs_in_stage
    import tbs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tbs_cmd_if.sink       cmd,
    input  logic          advance,
    output logic          item_valid,
    output cmd_item_t     item
);

    logic      valid_reg;
    logic      valid_next;
    cmd_item_t item_reg;
    logic      take;

    // free when empty or when the held item moves on this cycle
    assign cmd.ready = !valid_reg || advance;
    assign take = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (take)
        begin
            item_reg.command <= cmd.command;
            item_reg.frame_index <= cmd.frame_index;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

// ===== hw/rtl/tbs_core.sv =====
// slot roles, lock count and per-role frame indexes with the swap logic
module tbs_core
    import tbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  cmd_item_t item,
    output res_item_t result
);

    // frame indexes travel with their role, so no indexed read is needed
    logic [SLOT_W-1:0]         front_reg, front_next;
    logic [SLOT_W-1:0]         middle_reg, middle_next;
    logic [SLOT_W-1:0]         back_reg, back_next;
    logic signed [INDEX_W-1:0] front_idx_reg, front_idx_next;
    logic signed [INDEX_W-1:0] middle_idx_reg, middle_idx_next;
    logic signed [INDEX_W-1:0] back_idx_reg, back_idx_next;
    logic [LOCK_W-1:0]         count_reg, count_next;
    logic [LOCK_W-1:0]         count_dec;
    command_t                  cmd;

    assign cmd = command_t'(item.command);
    assign count_dec = count_reg - 1'b1;

    // next state and result for the held item
    always_comb
    begin
        front_next = front_reg;
        middle_next = middle_reg;
        back_next = back_reg;
        front_idx_next = front_idx_reg;
        middle_idx_next = middle_idx_reg;
        back_idx_next = back_idx_reg;
        count_next = count_reg;
        result.slot = front_reg;
        result.ready_res = 1'b0;
        result.ready_frame_index = '0;
        result.error = 1'b0;

        unique case (cmd)
            CMD_LOCK:
            begin
                if (count_reg >= LOCK_LIMIT)
                begin
                    count_next = LOCK_LIMIT;
                    result.error = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_UNLOCK:
            begin
                if (count_reg == '0)
                begin
                    result.error = 1'b1;
                end
                else
                begin
                    count_next = count_dec;
                    // last lock gone: promote a newer middle frame
                    if (count_dec == '0 && middle_idx_reg != EMPTY_INDEX
                        && middle_idx_reg > front_idx_reg)
                    begin
                        front_next = middle_reg;
                        middle_next = front_reg;
                        front_idx_next = middle_idx_reg;
                        middle_idx_next = front_idx_reg;
                        result.slot = middle_reg;
                        result.ready_res = 1'b1;
                        result.ready_frame_index = middle_idx_reg[READY_INDEX_W-1:0];
                    end
                end
            end
            CMD_PUBLISH:
            begin
                if (count_reg != '0)
                begin
                    // front is held: new frame waits in middle
                    back_next = middle_reg;
                    middle_next = back_reg;
                    back_idx_next = middle_idx_reg;
                    middle_idx_next = item.frame_index;
                    result.slot = middle_reg;
                end
                else
                begin
                    // front is free: new frame goes straight to front
                    front_next = back_reg;
                    back_next = front_reg;
                    front_idx_next = item.frame_index;
                    back_idx_next = front_idx_reg;
                    result.slot = front_reg;
                    if (item.frame_index != EMPTY_INDEX)
                    begin
                        result.ready_res = 1'b1;
                        result.ready_frame_index = item.frame_index[READY_INDEX_W-1:0];
                    end
                end
            end
            default:
            begin
                result.slot = front_reg;
            end
        endcase

        result.locks_held = count_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= FRONT_RESET;
            middle_reg <= MIDDLE_RESET;
            back_reg <= BACK_RESET;
            front_idx_reg <= EMPTY_INDEX;
            middle_idx_reg <= EMPTY_INDEX;
            back_idx_reg <= EMPTY_INDEX;
            count_reg <= '0;
        end
        else if (advance)
        begin
            front_reg <= front_next;
            middle_reg <= middle_next;
            back_reg <= back_next;
            front_idx_reg <= front_idx_next;
            middle_idx_reg <= middle_idx_next;
            back_idx_reg <= back_idx_next;
            count_reg <= count_next;
        end
    end

    // the three roles always name three different slots
    a_roles_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg != middle_reg && middle_reg != back_reg && front_reg != back_reg)
        else $error("slot roles overlap");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LOCK_LIMIT)
        else $error("lock count beyond limit");

    // a publish with no locks moves the old back slot to front
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd == CMD_PUBLISH && count_reg == '0
        |=> front_reg == $past(back_reg) && back_reg == $past(front_reg))
        else $error("unlocked publish did not swap front and back");

    a_ready_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.ready_res |-> !result.error)
        else $error("ready and error on the same item");

endmodule

// ===== hw/rtl/tbs_out_stage.sv =====
// result register toward the consumer side
module tbs_out_stage
    import tbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      result_valid,
    input  res_item_t result,
    output logic      can_take,
    tbs_res_if.source res
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t res_reg;
    logic      load;

    // the register can load when empty or being drained
    assign can_take = !valid_reg || res.ready;
    assign load = result_valid && can_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign res.valid = valid_reg;
    assign res.slot = res_reg.slot;
    assign res.ready_res = res_reg.ready_res;
    assign res.ready_frame_index = res_reg.ready_frame_index;
    assign res.error = res_reg.error;
    assign res.locks_held = res_reg.locks_held;

endmodule

// ===== hw/rtl/triple_buffer_swap_controller.sv =====
// Triple buffer swap controller: tracks which of three frame slots is front, middle and
// back, counts consumer locks on the front slot and swaps roles on unlock and publish.
// Every command item yields exactly one result item. Items pass an input register and then a
// result register, and one item is accepted every cycle as long as the result side keeps
// taking items; the only loop is the update of the role and lock registers. Reset leaves
// all three slots empty with slot 0 in front, slot 1 in middle and slot 2 in back.
module triple_buffer_swap_controller
    import tbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tbs_cmd_if.sink   cmd,
    tbs_res_if.source res
);

    logic      item_valid;
    logic      out_ready;
    cmd_item_t item;
    res_item_t result;
    logic      advance;

    // held item moves into the core when the result register can take it
    assign advance = item_valid && out_ready;

    tbs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tbs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    tbs_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_valid (item_valid),
        .result       (result),
        .can_take     (out_ready),
        .res          (res)
    );

endmodule
